[rtl/mrpd_pkg.sv]
`timescale 1ns / 1ps
package mrpd_pkg;

	// Input item: one PDU byte plus framing flags
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_pdu;
	} in_item_t;

	// Result item: register value, bit group or final status
	typedef struct packed {
		logic [1:0]  item_kind;
		logic [10:0] element_index;
		logic [15:0] data_value;
		logic [3:0]  bit_count;
		logic [15:0] echo_address;
		logic [1:0]  status;
		logic [3:0]  malformed_reason;
		logic [7:0]  exception_code;
		logic [6:0]  original_function;
		logic        last_item;
	} out_item_t;

	// Result kinds
	localparam logic [1:0] KIND_REG    = 2'd0;
	localparam logic [1:0] KIND_BITS   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Final status codes
	localparam logic [1:0] ST_SUCCESS   = 2'd0;
	localparam logic [1:0] ST_EXCEPTION = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	// Malformed reasons
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_EMPTY       = 4'd1;
	localparam logic [3:0] ERR_NO_EXC      = 4'd2;
	localparam logic [3:0] ERR_WRONG_FN    = 4'd3;
	localparam logic [3:0] ERR_NO_COUNT    = 4'd4;
	localparam logic [3:0] ERR_ODD         = 4'd5;
	localparam logic [3:0] ERR_SHORT       = 4'd6;
	localparam logic [3:0] ERR_MISMATCH    = 4'd7;
	localparam logic [3:0] ERR_WRITE_SHORT = 4'd8;

	// Response forms
	localparam logic [1:0] FORM_REGS      = 2'd0;
	localparam logic [1:0] FORM_BITS      = 2'd1;
	localparam logic [1:0] FORM_WR_SINGLE = 2'd2;
	localparam logic [1:0] FORM_WR_MULTI  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_FORM = 2'd0;
	localparam logic [1:0] CFG_FUNC = 2'd1;
	localparam logic [1:0] CFG_QTY  = 2'd2;

	localparam logic [7:0] RESET_FUNC    = 8'd3;
	localparam logic [6:0] TOP_MASK      = 7'h7F;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [8:0] WRITE_MIN_LEN = 9'd5;
	localparam logic [8:0] POS_MAX       = 9'd511;

	// Result queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

endpackage

[rtl/modbus_response_pdu_decoder.sv]
`timescale 1ns / 1ps
// Modbus response PDU decoder. Feed the PDU one byte per input transfer; mark
// the last transfer with end_of_pdu (a transfer with byte_present low and
// end_of_pdu high is a bare end marker). Register values or bit groups stream
// out as their bytes arrive, and every PDU ends with one status result
// (last_item high); streamed values are valid only if that status is success.
// One input transfer is taken every cycle while the result queue has room for
// two entries; the output side delivers one result per cycle while out_ready
// is high, and a byte that yields both a value and the status queues the value
// first. Results are registered in the queue before reaching the output.
// Configuration writes are always accepted and should be issued only between PDUs.
module modbus_response_pdu_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrpd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mrpd_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data
);
	import mrpd_pkg::*;

	logic      room2;
	logic      take;
	logic      val_push;
	logic      stat_push;
	out_item_t val_item;
	out_item_t stat_item;

	assign in_ready  = room2;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Byte parser and PDU state
	mrpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (in_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.val_push  (val_push),
		.val_item  (val_item),
		.stat_push (stat_push),
		.stat_item (stat_item)
	);

	// Result queue toward the output channel
	mrpd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (val_push),
		.data_a    (val_item),
		.push_b    (stat_push),
		.data_b    (stat_item),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[rtl/mrpd_parser.sv]
`timescale 1ns / 1ps
module mrpd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  mrpd_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	output logic                val_push,
	output mrpd_pkg::out_item_t val_item,
	output logic                stat_push,
	output mrpd_pkg::out_item_t stat_item
);
	import mrpd_pkg::*;

	// Configuration
	logic [1:0]  form_q;
	logic [7:0]  func_q;
	logic [10:0] qty_q;

	// Per-PDU state
	logic [8:0]  pos_q,      nx_pos;
	logic [7:0]  seen_fn_q,  nx_seen_fn;
	logic [7:0]  decl_q,     nx_decl;
	logic        is_exc_q,   nx_is_exc;
	logic [3:0]  early_q,    nx_early;
	logic [7:0]  hold_q,     nx_hold;
	logic [10:0] emit_idx_q, nx_emit_idx;
	logic [7:0]  saved_exc_q, nx_saved_exc;
	logic [15:0] echo1_q,    nx_echo1;
	logic [15:0] echo2_q,    nx_echo2;

	logic [7:0]  b;
	logic [8:0]  off;
	logic        in_count;
	logic [10:0] first;
	logic [10:0] left;
	logic [8:0]  need;
	logic [11:0] need_sum;
	logic        short_len;
	logic [3:0]  reason;
	logic        made;

	assign b        = item.data_byte;
	assign off      = pos_q - 9'd2;
	assign in_count = off < {1'b0, decl_q};
	assign first    = {off[7:0], 3'b000};
	assign left     = qty_q - first;
	assign need_sum = {1'b0, qty_q} + 12'd7;
	assign need     = need_sum[11:3];

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q <= FORM_REGS;
			func_q <= RESET_FUNC;
			qty_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORM: form_q <= cfg_data[1:0];
				CFG_FUNC: func_q <= cfg_data[7:0];
				CFG_QTY:  qty_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Byte handling and value results
	always_comb begin
		nx_pos       = pos_q;
		nx_seen_fn   = seen_fn_q;
		nx_decl      = decl_q;
		nx_is_exc    = is_exc_q;
		nx_early     = early_q;
		nx_hold      = hold_q;
		nx_emit_idx  = emit_idx_q;
		nx_saved_exc = saved_exc_q;
		nx_echo1     = echo1_q;
		nx_echo2     = echo2_q;
		made         = 1'b0;
		val_item     = '0;
		if (item.byte_present) begin
			if (pos_q == 9'd0) begin
				nx_seen_fn = b;
				if (b[7]) nx_is_exc = 1'b1;
				else if (b != func_q) nx_early = ERR_WRONG_FN;
			end else if (is_exc_q) begin
				if (pos_q == 9'd1) nx_saved_exc = b;
			end else if (early_q == ERR_WRONG_FN) begin
				// rest of PDU ignored
			end else if (form_q == FORM_WR_SINGLE || form_q == FORM_WR_MULTI) begin
				case (pos_q)
					9'd1:    nx_echo1 = {b, echo1_q[7:0]};
					9'd2:    nx_echo1 = {echo1_q[15:8], b};
					9'd3:    nx_echo2 = {b, echo2_q[7:0]};
					9'd4:    nx_echo2 = {echo2_q[15:8], b};
					default: ;
				endcase
			end else if (pos_q == 9'd1) begin
				nx_decl     = b;
				nx_emit_idx = '0;
				if (form_q == FORM_REGS && b[0]) nx_early = ERR_ODD;
			end else if (early_q == ERR_NONE && in_count) begin
				if (form_q == FORM_REGS) begin
					if (!off[0]) begin
						nx_hold = b;
					end else begin
						made                   = 1'b1;
						val_item.item_kind     = KIND_REG;
						val_item.element_index = emit_idx_q;
						val_item.data_value    = {hold_q, b};
						nx_emit_idx            = emit_idx_q + 11'd1;
					end
				end else if (first < qty_q) begin
					made                   = 1'b1;
					val_item.item_kind     = KIND_BITS;
					val_item.element_index = first;
					val_item.data_value    = {8'd0, b};
					val_item.bit_count     = (left < 11'(BITS_PER_BYTE)) ? left[3:0]
						: BITS_PER_BYTE;
					nx_emit_idx            = first + 11'(BITS_PER_BYTE);
				end
			end
			if (pos_q != POS_MAX) nx_pos = pos_q + 9'd1;
		end
	end

	// Final status, judged on the state after this item's byte
	assign short_len = {1'b0, nx_pos} < (10'd2 + {2'b00, nx_decl});

	always_comb begin
		reason              = ERR_NONE;
		stat_item           = '0;
		stat_item.item_kind = KIND_STATUS;
		stat_item.last_item = 1'b1;
		if (nx_pos == 9'd0) begin
			reason = ERR_EMPTY;
		end else if (nx_is_exc) begin
			if (nx_pos < 9'd2) reason = ERR_NO_EXC;
		end else if (nx_early == ERR_WRONG_FN) begin
			reason = ERR_WRONG_FN;
		end else if (form_q == FORM_WR_SINGLE || form_q == FORM_WR_MULTI) begin
			if (nx_pos < WRITE_MIN_LEN) reason = ERR_WRITE_SHORT;
		end else if (nx_pos < 9'd2) begin
			reason = ERR_NO_COUNT;
		end else if (form_q == FORM_REGS) begin
			if (nx_decl[0]) reason = ERR_ODD;
			else if (short_len) reason = ERR_SHORT;
		end else begin
			if (short_len) reason = ERR_SHORT;
			else if ({1'b0, nx_decl} != need) reason = ERR_MISMATCH;
		end

		if (reason != ERR_NONE) begin
			stat_item.status           = ST_MALFORMED;
			stat_item.malformed_reason = reason;
		end else if (nx_is_exc) begin
			stat_item.status            = ST_EXCEPTION;
			stat_item.exception_code    = nx_saved_exc;
			stat_item.original_function = nx_seen_fn[6:0] & TOP_MASK;
		end else if (form_q == FORM_WR_SINGLE || form_q == FORM_WR_MULTI) begin
			stat_item.status       = ST_SUCCESS;
			stat_item.data_value   = nx_echo2;
			stat_item.echo_address = nx_echo1;
		end else begin
			stat_item.status = ST_SUCCESS;
		end
	end

	assign val_push  = take && made;
	assign stat_push = take && item.end_of_pdu;

	// State update; end of PDU clears all per-PDU state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seen_fn_q   <= '0;
			decl_q      <= '0;
			is_exc_q    <= 1'b0;
			early_q     <= ERR_NONE;
			hold_q      <= '0;
			emit_idx_q  <= '0;
			saved_exc_q <= '0;
			echo1_q     <= '0;
			echo2_q     <= '0;
		end else if (take) begin
			if (item.end_of_pdu) begin
				pos_q       <= '0;
				seen_fn_q   <= '0;
				decl_q      <= '0;
				is_exc_q    <= 1'b0;
				early_q     <= ERR_NONE;
				hold_q      <= '0;
				emit_idx_q  <= '0;
				saved_exc_q <= '0;
				echo1_q     <= '0;
				echo2_q     <= '0;
			end else begin
				pos_q       <= nx_pos;
				seen_fn_q   <= nx_seen_fn;
				decl_q      <= nx_decl;
				is_exc_q    <= nx_is_exc;
				early_q     <= nx_early;
				hold_q      <= nx_hold;
				emit_idx_q  <= nx_emit_idx;
				saved_exc_q <= nx_saved_exc;
				echo1_q     <= nx_echo1;
				echo2_q     <= nx_echo2;
			end
		end
	end

`ifndef SYNTHESIS
	// Position saturates instead of wrapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && pos_q == POS_MAX && !item.end_of_pdu) |=> (pos_q == POS_MAX))
		else $error("byte position wrapped");

	// Values are only streamed for a non-exception PDU
	assert property (@(posedge clk) disable iff (!arst_n)
		val_push |-> (!is_exc_q && pos_q >= 9'd2))
		else $error("value result outside data bytes");
`endif

endmodule

[rtl/mrpd_result_fifo.sv]
`timescale 1ns / 1ps
module mrpd_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  mrpd_pkg::out_item_t data_a,
	input  logic                push_b,
	input  mrpd_pkg::out_item_t data_b,
	output logic                room2,
	output logic                out_valid,
	input  logic                out_ready,
	output mrpd_pkg::out_item_t out_data
);
	import mrpd_pkg::*;

	out_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_b;
	logic [1:0]       npush;
	logic             pop;

	assign npush     = {1'b0, push_a} + {1'b0, push_b};
	assign pop       = out_valid && out_ready;
	assign wr_b      = push_a ? wr_q + PTR_W'(1) : wr_q;
	assign room2     = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];

	// Storage: the value result lands ahead of the status of the same item
	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_q] <= data_a;
		if (push_b) mem_q[wr_b] <= data_b;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(npush);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(npush) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	// Pushes never exceed the free space
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_a || push_b) |-> ((count_q + CNT_W'(npush)) <= CNT_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	// Fill level never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count out of range");

	// Fill level tracks pushes and pops
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) + CNT_W'($past(npush)) - CNT_W'($past(pop))))
		else $error("result queue count drift");
`endif

endmodule
